>>> design/afft_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package afft_pkg;

    localparam int REG_COUNT = 8;

    typedef enum logic [2:0] {
        REG_M11   = 3'd0,
        REG_M12   = 3'd1,
        REG_M21   = 3'd2,
        REG_M22   = 3'd3,
        REG_OFF_X = 3'd4,
        REG_OFF_Y = 3'd5,
        REG_SCALE = 3'd6,
        REG_MODE  = 3'd7
    } t_reg_idx;

endpackage

`default_nettype wire

>>> design/afft_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module afft_regs #(
    parameter int W  = 32,
    parameter int F  = 16,
    parameter int AW = 5,
    parameter int DW = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [AW-1:0]        paddr,
    input  wire logic [DW-1:0]        pwdata,
    output logic      [DW-1:0]        prdata,
    output logic                      pready,
    output logic signed [W-1:0]       o_m11,
    output logic signed [W-1:0]       o_m12,
    output logic signed [W-1:0]       o_m21,
    output logic signed [W-1:0]       o_m22,
    output logic signed [W-1:0]       o_off_x,
    output logic signed [W-1:0]       o_off_y,
    output logic signed [W-1:0]       o_scale,
    output logic                      o_mode
);
    import afft_pkg::*;

    localparam logic [W-1:0] ONE_R = {{(W-1){1'b0}}, 1'b1} << F;

    logic [W-1:0] r_m11, r_m12, r_m21, r_m22, r_offx, r_offy, r_scale;
    logic         r_mode;
    t_reg_idx     idx;
    logic         wr;

    assign idx    = t_reg_idx'(paddr[AW-1:AW-3]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m11   <= ONE_R;
            r_m12   <= '0;
            r_m21   <= '0;
            r_m22   <= ONE_R;
            r_offx  <= '0;
            r_offy  <= '0;
            r_scale <= ONE_R;
            r_mode  <= 1'b0;
        end else if (wr) begin
            unique case (idx)
                REG_M11:   r_m11   <= pwdata[W-1:0];
                REG_M12:   r_m12   <= pwdata[W-1:0];
                REG_M21:   r_m21   <= pwdata[W-1:0];
                REG_M22:   r_m22   <= pwdata[W-1:0];
                REG_OFF_X: r_offx  <= pwdata[W-1:0];
                REG_OFF_Y: r_offy  <= pwdata[W-1:0];
                REG_SCALE: r_scale <= pwdata[W-1:0];
                REG_MODE:  r_mode  <= pwdata[0];
                default:   ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_M11:   prdata = DW'(r_m11);
            REG_M12:   prdata = DW'(r_m12);
            REG_M21:   prdata = DW'(r_m21);
            REG_M22:   prdata = DW'(r_m22);
            REG_OFF_X: prdata = DW'(r_offx);
            REG_OFF_Y: prdata = DW'(r_offy);
            REG_SCALE: prdata = DW'(r_scale);
            REG_MODE:  prdata = DW'(r_mode);
            default:   prdata = '0;
        endcase
    end

    assign o_m11   = r_m11;
    assign o_m12   = r_m12;
    assign o_m21   = r_m21;
    assign o_m22   = r_m22;
    assign o_off_x = r_offx;
    assign o_off_y = r_offy;
    assign o_scale = r_scale;
    assign o_mode  = r_mode;

endmodule

`default_nettype wire

>>> design/afft_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Two-lane restoring divider, one quotient bit per stage, shared divisor.
module afft_div #(
    parameter int W  = 32,
    parameter int SB = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [W-1:0]  i_dm,
    input  wire logic [W-1:0]  i_hi_x,
    input  wire logic [W-1:0]  i_lo_x,
    input  wire logic [W-1:0]  i_hi_y,
    input  wire logic [W-1:0]  i_lo_y,
    input  wire logic [SB-1:0] i_side,
    output logic               o_valid,
    output logic [W-1:0]       o_q_x,
    output logic [W-1:0]       o_q_y,
    output logic [SB-1:0]      o_side
);
    import afft_pkg::*;

    logic          r_v    [W+1];
    logic [W-1:0]  r_dm   [W+1];
    logic [W-1:0]  r_rx   [W+1];
    logic [W-1:0]  r_lx   [W+1];
    logic [W-1:0]  r_qx   [W+1];
    logic [W-1:0]  r_ry   [W+1];
    logic [W-1:0]  r_ly   [W+1];
    logic [W-1:0]  r_qy   [W+1];
    logic [SB-1:0] r_sd   [W+1];

    // entry stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
        r_dm[0] <= i_dm;
        r_rx[0] <= i_hi_x;
        r_lx[0] <= i_lo_x;
        r_qx[0] <= '0;
        r_ry[0] <= i_hi_y;
        r_ly[0] <= i_lo_y;
        r_qy[0] <= '0;
        r_sd[0] <= i_side;
    end

    for (genvar k = 0; k < W; k++) begin : g_st
        logic [W:0] tx, ty;
        logic       gx, gy;

        always_comb begin
            tx = {r_rx[k], r_lx[k][W-1]};
            ty = {r_ry[k], r_ly[k][W-1]};
            gx = tx >= {1'b0, r_dm[k]};
            gy = ty >= {1'b0, r_dm[k]};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else begin
                r_v[k+1] <= r_v[k];
            end
            r_dm[k+1] <= r_dm[k];
            r_rx[k+1] <= gx ? W'(tx - {1'b0, r_dm[k]}) : tx[W-1:0];
            r_ry[k+1] <= gy ? W'(ty - {1'b0, r_dm[k]}) : ty[W-1:0];
            r_lx[k+1] <= r_lx[k] << 1;
            r_ly[k+1] <= r_ly[k] << 1;
            r_qx[k+1] <= {r_qx[k][W-2:0], gx};
            r_qy[k+1] <= {r_qy[k][W-2:0], gy};
            r_sd[k+1] <= r_sd[k];
        end
    end

    assign o_valid = r_v[W];
    assign o_q_x   = r_qx[W];
    assign o_q_y   = r_qy[W];
    assign o_side  = r_sd[W];

endmodule

`default_nettype wire

>>> design/affine_point_transform_2d.sv
`timescale 1ns / 1ps
`default_nettype none

// 2D affine point transform, signed fixed point (WORD_BITS wide, FRACTION_BITS
// fraction). One point is taken on every cycle that start is high; busy stays
// low, so the block never refuses a word. Each result appears on the o_ ports
// for one cycle with o_valid high, once its point has passed the product,
// row-sum, divider and output registers; the receiver cannot stall it, so
// sample it then. The latency is set by the Cartesian divider, which resolves
// one quotient bit per stage; the homogeneous path rides alongside so both
// modes share one fixed latency. Configuration goes through the APB port;
// write it only while no point is in flight.
module affine_point_transform_2d #(
    parameter int WORD_BITS     = 32,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic signed [WORD_BITS-1:0]  i_x_in,
    input  wire logic signed [WORD_BITS-1:0]  i_y_in,
    input  wire logic signed [WORD_BITS-1:0]  i_w_in,
    output logic                              o_valid,
    output logic signed [WORD_BITS-1:0]       o_x_out,
    output logic signed [WORD_BITS-1:0]       o_y_out,
    output logic signed [WORD_BITS-1:0]       o_w_out,
    output logic                              o_divide_error,
    output logic                              o_saturated,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [$clog2(afft_pkg::REG_COUNT)+((WORD_BITS>32)?3:2)-1:0] paddr,
    input  wire logic [((WORD_BITS>32)?64:32)-1:0] pwdata,
    output logic      [((WORD_BITS>32)?64:32)-1:0] prdata,
    output logic                              pready
);
    import afft_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int F  = FRACTION_BITS;
    localparam int AW = $clog2(REG_COUNT) + ((W > 32) ? 3 : 2);
    localparam int DW = (W > 32) ? 64 : 32;
    localparam int S  = 2*W + 2;           // exact row sum width
    localparam int SB = 3*W + 3;           // sideband through the divider

    localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [S-1:0] SMAX = S'(WMAX);
    localparam logic signed [S-1:0] SMIN = -SMAX - S'(1);
    // Cartesian weight of 1.0; clip when it does not fit the word
    localparam logic         ONE_SAT = (F >= W-1);
    localparam logic [W-1:0] ONE_VAL = ONE_SAT ? WMAX : ({{(W-1){1'b0}}, 1'b1} << F);

    logic signed [W-1:0] m11, m12, m21, m22, offx, offy, scale;
    logic                mode;

    afft_regs #(.W(W), .F(F), .AW(AW), .DW(DW)) u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_m11   (m11),
        .o_m12   (m12),
        .o_m21   (m21),
        .o_m22   (m22),
        .o_off_x (offx),
        .o_off_y (offy),
        .o_scale (scale),
        .o_mode  (mode)
    );

    assign busy = 1'b0;

    // Rescale by the fraction bits and clip to the word: {clipped, value}.
    function automatic logic [W:0] clip_s(input logic signed [S-1:0] v);
        logic signed [S-1:0] t;
        t = v >>> F;
        if (t > SMAX)      return {1'b1, WMAX};
        else if (t < SMIN) return {1'b1, WMIN};
        else               return {1'b0, t[W-1:0]};
    endfunction

    // Stage 1: products.
    logic                   r_v1;
    logic signed [2*W-1:0]  r_p11, r_p12, r_p21, r_p22, r_pw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= start;
        end
        r_p11 <= m11 * i_x_in;
        r_p12 <= m12 * i_y_in;
        r_p21 <= m21 * i_x_in;
        r_p22 <= m22 * i_y_in;
        r_pw  <= i_w_in * scale;
    end

    // Stage 2: row sums, offset aligned to the doubled fraction.
    logic                  r_v2;
    logic signed [S-1:0]   r_sx, r_sy;
    logic signed [2*W-1:0] r_pw2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_sx  <= S'(r_p11) + S'(r_p12) + (S'(offx) <<< F);
        r_sy  <= S'(r_p21) + S'(r_p22) + (S'(offy) <<< F);
        r_pw2 <= r_pw;
    end

    // Stage 3 (combinational into divider entry): split into sign and
    // magnitude, flag quotients that overflow the word before dividing.
    logic          nx, ny, dn, dz, ovx, ovy, sgx, sgy;
    logic [S-1:0]  magx, magy;
    logic [W-1:0]  dm;
    logic [W:0]    hx, hy, hw;
    logic [SB-1:0] side;

    always_comb begin
        nx   = r_sx[S-1];
        ny   = r_sy[S-1];
        magx = nx ? S'(-r_sx) : S'(r_sx);
        magy = ny ? S'(-r_sy) : S'(r_sy);
        dn   = scale[W-1];
        dm   = dn ? W'(-scale) : W'(scale);
        dz   = (scale == '0);
        ovx  = dz || (magx[S-1:W] >= {2'b00, dm});
        ovy  = dz || (magy[S-1:W] >= {2'b00, dm});
        // a zero divisor clips toward the sign of the sum itself
        sgx  = dz ? nx : (nx ^ dn);
        sgy  = dz ? ny : (ny ^ dn);
        hx   = clip_s(r_sx);
        hy   = clip_s(r_sy);
        hw   = clip_s(S'(r_pw2));
        side = {mode, dz, hx[W] | hy[W] | hw[W], hx[W-1:0], hy[W-1:0], hw[W-1:0]};
    end

    logic [3:0] r_fl [W+1];   // {sign x, ovf x, sign y, ovf y} per divider stage

    always_ff @(posedge i_clk) begin
        r_fl[0] <= {sgx, ovx, sgy, ovy};
        for (int k = 0; k < W; k++) begin
            r_fl[k+1] <= r_fl[k];
        end
    end

    logic          dv;
    logic [W-1:0]  qx, qy;
    logic [SB-1:0] dside;

    afft_div #(.W(W), .SB(SB)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v2),
        .i_dm    (dm),
        .i_hi_x  (magx[2*W-1:W]),
        .i_lo_x  (magx[W-1:0]),
        .i_hi_y  (magy[2*W-1:W]),
        .i_lo_y  (magy[W-1:0]),
        .i_side  (side),
        .o_valid (dv),
        .o_q_x   (qx),
        .o_q_y   (qy),
        .o_side  (dside)
    );

    // Signed quotient clip: {clipped, value}.
    function automatic logic [W:0] clip_q(input logic neg, input logic ovf,
                                          input logic [W-1:0] q);
        if (ovf)             return {1'b1, neg ? WMIN : WMAX};
        else if (neg)        return (q > WMIN) ? {1'b1, WMIN} : {1'b0, W'(-q)};
        else                 return (q > WMAX) ? {1'b1, WMAX} : {1'b0, q};
    endfunction

    // Final stage: pick the mode's result and register it.
    logic          f_mode, f_dz, f_hsat;
    logic [W:0]    cx, cy;
    logic [3:0]    fl;
    logic [W-1:0]  n_x, n_y, n_w;
    logic          n_derr, n_sat;

    always_comb begin
        f_mode = dside[SB-1];
        f_dz   = dside[SB-2];
        f_hsat = dside[SB-3];
        fl     = r_fl[W];
        cx     = clip_q(fl[3], fl[2], qx);
        cy     = clip_q(fl[1], fl[0], qy);
        if (f_mode) begin
            n_x    = dside[3*W-1:2*W];
            n_y    = dside[2*W-1:W];
            n_w    = dside[W-1:0];
            n_derr = 1'b0;
            n_sat  = f_hsat;
        end else begin
            n_x    = cx[W-1:0];
            n_y    = cy[W-1:0];
            n_w    = ONE_VAL;
            n_derr = f_dz;
            n_sat  = cx[W] | cy[W] | ONE_SAT;
        end
    end

    logic         r_ov;
    logic [W-1:0] r_x, r_y, r_w;
    logic         r_derr, r_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= dv;
        end
        r_x    <= n_x;
        r_y    <= n_y;
        r_w    <= n_w;
        r_derr <= n_derr;
        r_sat  <= n_sat;
    end

    assign o_valid        = r_ov;
    assign o_x_out        = r_x;
    assign o_y_out        = r_y;
    assign o_w_out        = r_w;
    assign o_divide_error = r_derr;
    assign o_saturated    = r_sat;

endmodule

`default_nettype wire
